// ----- hdl/ssr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants for the streaming substring replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int MAX_PATTERN_DEF     = 8;
	localparam int MAX_REPLACEMENT_DEF = 8;
	localparam int CFG_IDX_W           = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LEN       = 4'd0,
		REG_PATTERN_BYTES     = 4'd1,
		REG_REPLACEMENT_LEN   = 4'd2,
		REG_REPLACEMENT_BYTES = 4'd3
	} cfg_reg_t;

	// per-cell control from the window sequencer
	typedef struct packed {
		logic load;   // incoming byte lands in this cell
		logic shift;  // window moves by one toward the oldest cell
	} cell_ctl_t;

	// handoff of one result burst to the output serializer
	typedef struct packed {
		logic load;
		logic last;
	} burst_ctl_t;

endpackage

// ----- hdl/stream_substring_replace.sv -----
// ----------------------------------------------------------------------------
// stream_substring_replace
// Streaming find-and-replace of a configured pattern in a byte stream.
// ----------------------------------------------------------------------------
// Bytes enter a two-entry input queue and then a row of window cells, one
// per pattern byte, that compare against the pattern in parallel. Results are
// registered in the output serializer before they reach the output. Throughput
// is one byte per cycle as long as each input produces at most one output
// byte and the output is not stalled; a match with a k-byte replacement, or
// a flush of k window bytes at end of stream, occupies the single output
// serializer until all k bytes are sent, and the input stalls once the queue
// is full. A final input that produces no byte yields one marker-only result.
module stream_substring_replace #(
	parameter int MAX_PATTERN     = ssr_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = ssr_pkg::MAX_REPLACEMENT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          out_has_byte,
	output logic                          out_last
);
	import ssr_pkg::*;

	localparam int BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int CNT_W = $clog2(MAX_PATTERN+1);
	localparam int RL_W  = $clog2(MAX_REPLACEMENT+1);
	localparam int N_W   = $clog2(BURST+1);

	// configuration
	logic [3:0]  pattern_len_q;
	logic [63:0] pattern_bytes_q;
	logic [3:0]  replacement_len_q;
	logic [63:0] replacement_bytes_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q       <= '0;
			pattern_bytes_q     <= '0;
			replacement_len_q   <= '0;
			replacement_bytes_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PATTERN_LEN:       pattern_len_q       <= cfg_data[3:0];
				REG_PATTERN_BYTES:     pattern_bytes_q     <= cfg_data;
				REG_REPLACEMENT_LEN:   replacement_len_q   <= cfg_data[3:0];
				REG_REPLACEMENT_BYTES: replacement_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0] plen;
	logic [RL_W-1:0]  rlen;

	assign plen = (pattern_len_q > 4'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
	                                                 : CNT_W'(pattern_len_q);
	assign rlen = (replacement_len_q > 4'(MAX_REPLACEMENT)) ? RL_W'(MAX_REPLACEMENT)
	                                                         : RL_W'(replacement_len_q);

	// two-entry input queue
	logic [7:0] q_byte_q [2];
	logic       q_last_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] q_cnt_q;
	logic       push;
	logic       pop;

	assign in_stall = (q_cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			q_cnt_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_byte_q[wr_ptr_q] <= in_byte;
			q_last_q[wr_ptr_q] <= in_last;
		end
	end

	logic [7:0] cur_byte;
	logic       cur_last;
	logic       emit_ready;

	assign cur_byte = q_byte_q[rd_ptr_q];
	assign cur_last = q_last_q[rd_ptr_q];
	assign pop      = (q_cnt_q != 2'd0) && emit_ready;

	// window cells
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           cnt_a;
	logic [MAX_PATTERN-1:0][7:0] a_bytes;
	logic [MAX_PATTERN-1:0]     eq;
	logic                       over;
	logic                       at_len;
	logic                       hit;
	logic                       drop;

	assign cnt_a  = cnt_q + CNT_W'(1);
	assign over   = cnt_a > plen;
	assign at_len = cnt_a == plen;
	assign hit    = at_len && (&eq);
	assign drop   = over || (at_len && !hit);

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		cell_ctl_t  ctl;
		logic [7:0] nbr;

		assign ctl.load  = (cnt_q == CNT_W'(i));
		assign ctl.shift = drop;

		if (i == MAX_PATTERN - 1) begin : g_end
			assign nbr = 8'h00;
		end else begin : g_mid
			assign nbr = a_bytes[i+1];
		end

		ssr_cell u_cell (
			.clk      (clk),
			.take     (pop),
			.ctl      (ctl),
			.care     (CNT_W'(i) < plen),
			.pat_byte (pattern_bytes_q[8*i +: 8]),
			.in_byte  (cur_byte),
			.nbr_byte (nbr),
			.a_byte   (a_bytes[i]),
			.eq       (eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pop) begin
			priority if (hit || cur_last) begin
				cnt_q <= '0;
			end else if (drop) begin
				cnt_q <= cnt_a - CNT_W'(1);
			end else begin
				cnt_q <= cnt_a;
			end
		end
	end

	// result burst: replacement on a match, otherwise the whole window at end of
	// stream, the oldest byte when the window drops it, or no byte at all
	logic [BURST-1:0][7:0] burst_bytes;
	logic [N_W-1:0]        burst_n;
	burst_ctl_t            bctl;

	always_comb begin
		for (int j = 0; j < BURST; j++) begin
			burst_bytes[j] = 8'h00;
			if (hit) begin
				if (j < MAX_REPLACEMENT) begin
					burst_bytes[j] = replacement_bytes_q[8*j +: 8];
				end
			end else if (j < MAX_PATTERN) begin
				burst_bytes[j] = a_bytes[j];
			end
		end
	end

	always_comb begin
		priority if (hit) begin
			burst_n = N_W'(rlen);
		end else if (cur_last) begin
			burst_n = N_W'(cnt_a);
		end else if (drop) begin
			burst_n = N_W'(1);
		end else begin
			burst_n = '0;
		end
	end

	assign bctl.load = pop && ((burst_n != '0) || cur_last);
	assign bctl.last = cur_last;

	ssr_emit #(
		.BURST (BURST)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (bctl),
		.burst_bytes  (burst_bytes),
		.burst_n      (burst_n),
		.ready        (emit_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.out_has_byte (out_has_byte),
		.out_last     (out_last)
	);

endmodule

// ----- hdl/ssr_cell.sv -----
// ----------------------------------------------------------------------------
// ssr_cell
// One window byte: appends, shifts from its neighbor and compares against
// its pattern byte.
// ----------------------------------------------------------------------------
module ssr_cell (
	input  logic              clk,
	input  logic              take,
	input  ssr_pkg::cell_ctl_t ctl,
	input  logic              care,
	input  logic [7:0]        pat_byte,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        nbr_byte,
	output logic [7:0]        a_byte,
	output logic              eq
);
	import ssr_pkg::*;

	logic [7:0] w_q;

	// contents after the append
	assign a_byte = ctl.load ? in_byte : w_q;
	assign eq     = !care || (a_byte == pat_byte);

	always_ff @(posedge clk) begin
		if (take) begin
			w_q <= ctl.shift ? nbr_byte : a_byte;
		end
	end

endmodule

// ----- hdl/ssr_emit.sv -----
// ----------------------------------------------------------------------------
// ssr_emit
// Output serializer: holds one result burst and sends it a byte per transfer.
// ----------------------------------------------------------------------------
module ssr_emit #(
	parameter int BURST = ssr_pkg::MAX_PATTERN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssr_pkg::burst_ctl_t           ctl,
	input  logic [BURST-1:0][7:0]         burst_bytes,
	input  logic [$clog2(BURST+1)-1:0]    burst_n,
	output logic                          ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          out_has_byte,
	output logic                          out_last
);
	import ssr_pkg::*;

	localparam int N_W   = $clog2(BURST+1);
	localparam int IDX_W = (BURST > 1) ? $clog2(BURST) : 1;

	logic [7:0]       buf_q [BURST];
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [N_W-1:0]   n_q;
	logic             last_q;
	logic             mark_q;
	logic             fin;
	logic             xfer;

	// marker-only result when the burst is empty
	assign fin   = mark_q || (N_W'(idx_q) == (n_q - N_W'(1)));
	assign xfer  = busy_q && !out_stall;
	assign ready = !busy_q || (xfer && fin);

	assign out_valid    = busy_q;
	assign out_byte     = mark_q ? 8'h00 : buf_q[idx_q];
	assign out_has_byte = !mark_q;
	assign out_last     = last_q && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			n_q    <= '0;
			last_q <= 1'b0;
			mark_q <= 1'b0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			n_q    <= burst_n;
			last_q <= ctl.last;
			mark_q <= (burst_n == '0);
		end else if (xfer) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int j = 0; j < BURST; j++) begin
				buf_q[j] <= burst_bytes[j];
			end
		end
	end

endmodule
